// ===== src/pcta_pkg.sv =====
// Shared types, constants and helpers for the palette color type analyzer.
`timescale 1ns / 1ps
package pcta_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam int OP_W     = 3;
	localparam int PIXEL_W  = 32;
	localparam int EIDX_W   = 8;
	localparam int CTYPE_W  = 3;
	localparam int COUNT_W  = 9;
	localparam int PIDX_W   = 8;

	localparam logic [OP_W-1:0] OP_SCAN   = 3'd0;
	localparam logic [OP_W-1:0] OP_REPORT = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [CTYPE_W-1:0] CT_GRAY    = 3'd0;
	localparam logic [CTYPE_W-1:0] CT_RGB     = 3'd2;
	localparam logic [CTYPE_W-1:0] CT_PALETTE = 3'd3;
	localparam logic [CTYPE_W-1:0] CT_ALPHA   = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // latch the request and restart the search pointer
		logic search;   // walk the table one entry per cycle
		logic rd_entry; // address the table with the requested entry index
		logic apply;    // update table, count and flags
		logic emit;     // load the output register
	} pcta_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_done;
		logic table_full;
	} pcta_stat_t;

	function automatic logic [CTYPE_W-1:0] pcta_color_type(
		input logic color, input logic full, input logic partial, input logic alpha);
		logic [CTYPE_W-1:0] t;
		t = CT_PALETTE;
		if (!color)
			t = CT_GRAY;
		if ((full || partial) && color)
			t = CT_RGB;
		if (alpha && (t != CT_PALETTE))
			t = t | CT_ALPHA;
		return t;
	endfunction

endpackage

// ===== src/pcta_dpath.sv =====
// Datapath: color table memory, search pointer, sticky flags and output register.
`timescale 1ns / 1ps
module pcta_dpath #(
	parameter int TABLE_DEPTH = pcta_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcta_pkg::pcta_cmd_t               cmd,
	output pcta_pkg::pcta_stat_t              stat,
	input  logic [pcta_pkg::OP_W-1:0]         operation,
	input  logic [pcta_pkg::PIXEL_W-1:0]      pixel,
	input  logic [pcta_pkg::EIDX_W-1:0]       entry_index,
	output logic [pcta_pkg::CTYPE_W-1:0]      png_ctype,
	output logic [pcta_pkg::COUNT_W-1:0]      color_count,
	output logic                              has_alpha,
	output logic                              partial_alpha,
	output logic                              is_color,
	output logic                              overflow,
	output logic [pcta_pkg::PIDX_W-1:0]       palette_index,
	output logic                              found,
	output logic [pcta_pkg::PIXEL_W-1:0]      entry_value
);
	import pcta_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	logic [PIXEL_W-1:0] mem [TABLE_DEPTH];
	logic [PIXEL_W-1:0] rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;

	logic [OP_W-1:0]    op_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic [EIDX_W-1:0]  index_q;

	logic [CNT_W-1:0]   count_q;
	logic               alpha_q, partial_q, color_q, full_q;

	logic [CNT_W-1:0]   ptr_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               hit_now;
	logic               issue;

	logic [PIXEL_W-1:0] entry_val_q;

	logic [7:0] px_a, px_r, px_g, px_b;
	logic       index_ok;

	assign px_a = pixel_q[31:24];
	assign px_r = pixel_q[23:16];
	assign px_g = pixel_q[15:8];
	assign px_b = pixel_q[7:0];

	assign index_ok = (COUNT_W'(index_q) < COUNT_W'(count_q));

	// Search pipeline: address issued one cycle, compared the next.
	assign hit_now = cmd.search && pend_q && !hit_q && (rd_data_q == pixel_q);
	assign issue   = cmd.search && !hit_q && !hit_now && (ptr_q < count_q);

	assign stat.search_done = hit_q || (!pend_q && (ptr_q >= count_q));
	assign stat.table_full  = full_q;

	assign rd_addr = cmd.rd_entry ? index_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign wr_en   = cmd.apply && (op_q == OP_SCAN) && !full_q && !hit_q
		&& (count_q != DEPTH_CNT);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[IDX_W-1:0]] <= pixel_q;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			pixel_q <= pixel;
			index_q <= entry_index;
		end
		if (cmd.search)
			pend_idx_q <= ptr_q[IDX_W-1:0];
		if (hit_now)
			hit_idx_q <= pend_idx_q;
		if (cmd.apply)
			entry_val_q <= ((op_q == OP_READ) && index_ok) ? rd_data_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			pend_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.load) begin
			ptr_q  <= '0;
			pend_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.search) begin
			pend_q <= issue;
			if (hit_now)
				hit_q <= 1'b1;
			if (issue)
				ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			alpha_q   <= 1'b0;
			partial_q <= 1'b0;
			color_q   <= 1'b0;
			full_q    <= 1'b0;
		end else if (cmd.apply) begin
			if (op_q == OP_SCAN) begin
				if (px_a != ALPHA_OPAQUE)
					alpha_q <= 1'b1;
				if ((px_a != 8'h00) && (px_a != ALPHA_OPAQUE))
					partial_q <= 1'b1;
				if ((px_r != px_g) || (px_r != px_b))
					color_q <= 1'b1;
				if (!full_q && !hit_q) begin
					if (count_q == DEPTH_CNT)
						full_q <= 1'b1;
					else
						count_q <= count_q + 1'b1;
				end
			end else if (op_q == OP_CLEAR) begin
				count_q   <= '0;
				alpha_q   <= 1'b0;
				partial_q <= 1'b0;
				color_q   <= 1'b0;
				full_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			png_ctype     <= pcta_color_type(color_q, full_q, partial_q, alpha_q);
			color_count   <= COUNT_W'(count_q);
			has_alpha     <= alpha_q;
			partial_alpha <= partial_q;
			is_color      <= color_q;
			overflow      <= full_q;
			found         <= (op_q == OP_LOOKUP) && hit_q;
			palette_index <= ((op_q == OP_LOOKUP) && hit_q) ? PIDX_W'(hit_idx_q) : '0;
			entry_value   <= entry_val_q;
		end
	end

endmodule

// ===== src/pcta_ctrl.sv =====
// Controller: sequences one request through search, table access and result.
`timescale 1ns / 1ps
module pcta_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pcta_pkg::OP_W-1:0]  operation,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pcta_pkg::pcta_cmd_t        cmd,
	input  pcta_pkg::pcta_stat_t       stat
);
	import pcta_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SEARCH = 5'b00010,
		ST_RDENT  = 5'b00100,
		ST_APPLY  = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.search   = (state_q == ST_SEARCH);
		cmd.rd_entry = (state_q == ST_RDENT);
		cmd.apply    = (state_q == ST_APPLY);
		cmd.emit     = (state_q == ST_RESULT) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((operation == OP_LOOKUP)
						|| ((operation == OP_SCAN) && !stat.table_full))
						state_d = ST_SEARCH;
					else if (operation == OP_READ)
						state_d = ST_RDENT;
					else
						state_d = ST_APPLY;
				end
			end
			ST_SEARCH: begin
				if (stat.search_done)
					state_d = ST_APPLY;
			end
			ST_RDENT:  state_d = ST_APPLY;
			ST_APPLY:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/palette_color_type_analyzer_core.sv =====
// Top level of the palette color type analyzer: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Requests enter on in_valid/in_ready with operation, pixel and entry_index;
//   every request yields exactly one result on out_valid/out_ready.
//   Operations: scan a pixel into the color table and flags, report, look up
//   a pixel's palette index, read a table entry, clear table and flags.
// Timing:
//   One request is worked on at a time. After acceptance, report, clear and a
//   scan once the table has overflowed go straight to the update and the
//   result; read entry first reads the entry, and scan and lookup first search
//   the table. The table search reads one entry per cycle through the single
//   read port of the color memory, stopping at the first match.
//   in_ready rises again in the cycle after the result is loaded, so the
//   next request may be accepted while the previous result is still held.
// Reset:
//   arst_n clears the count, the four flags and the controller; the table
//   memory is not cleared, as only entries below the count are ever used.
// Stall:
//   A result held in the output register stays put while out_ready is low;
//   a following request finishes its work and then waits for the slot.
module palette_color_type_analyzer_core #(
	parameter int TABLE_DEPTH = pcta_pkg::TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pcta_pkg::OP_W-1:0]         operation,
	input  logic [pcta_pkg::PIXEL_W-1:0]      pixel,
	input  logic [pcta_pkg::EIDX_W-1:0]       entry_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pcta_pkg::CTYPE_W-1:0]      png_ctype,
	output logic [pcta_pkg::COUNT_W-1:0]      color_count,
	output logic                              has_alpha,
	output logic                              partial_alpha,
	output logic                              is_color,
	output logic                              overflow,
	output logic [pcta_pkg::PIDX_W-1:0]       palette_index,
	output logic                              found,
	output logic [pcta_pkg::PIXEL_W-1:0]      entry_value
);
	import pcta_pkg::*;

	// Command and status between the sequencer and the datapath.
	pcta_cmd_t  cmd;
	pcta_stat_t stat;

	// Sequence each request: dispatch on the operation, walk the table, update, emit.
	pcta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Hold the color table, count, sticky flags and the output register.
	pcta_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.pixel         (pixel),
		.entry_index   (entry_index),
		.png_ctype     (png_ctype),
		.color_count   (color_count),
		.has_alpha     (has_alpha),
		.partial_alpha (partial_alpha),
		.is_color      (is_color),
		.overflow      (overflow),
		.palette_index (palette_index),
		.found         (found),
		.entry_value   (entry_value)
	);

endmodule
